@@ hdl/ecs_pkg.sv @@
// shared types and constants of the edge candidate selector
// no dependencies
`default_nettype none

package ecs_pkg;

   localparam int MAX_CANDIDATES = 8;
   localparam int COORD_W        = 16;
   localparam int DIFF_W         = 17;
   localparam int PROD_W         = 33;
   localparam int ACC_W          = 34;
   localparam int ROUND_SHIFT    = 14;
   localparam int DIST_W         = 24;
   localparam int ABS_W          = 23;
   localparam int RESP_W         = 16;
   localparam int IDX_W          = 3;
   localparam int MID_DEPTH      = 4;
   localparam int OUT_DEPTH      = 4;

   localparam int CSR_DATA_W     = 32;
   localparam int CSR_ADDR_W     = 3;

   localparam logic [ABS_W-1:0] DISTANCE_LIMIT_RESET = '1;
   localparam logic [ABS_W-1:0] HELD_ABS_RESET       = '1;

   typedef enum logic {
      REG_SELECT_MODE    = 1'b0,
      REG_DISTANCE_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic {
      MODE_NEAREST   = 1'b0,
      MODE_STRONGEST = 1'b1
   } select_mode_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0]  dx;
      logic signed [DIFF_W-1:0]  dy;
      logic signed [COORD_W-1:0] nx;
      logic signed [COORD_W-1:0] ny;
      logic [RESP_W-1:0]         resp;
      logic [IDX_W-1:0]          idx;
      logic                      considered;
      logic                      last;
      logic                      enabled;
   } mid_item_type;

   typedef struct packed {
      logic [RESP_W-1:0] resp;
      logic [IDX_W-1:0]  idx;
      logic              considered;
      logic              last;
      logic              enabled;
   } back_ctl_type;

   typedef struct packed {
      logic [IDX_W-1:0]         best_index;
      logic signed [DIST_W-1:0] signed_distance;
      logic [ABS_W-1:0]         abs_distance;
      logic                     is_inlier;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ hdl/ecs_fifo.sv @@
// small register-based queue used between pipeline sections
// no dependencies
`default_nettype none

module ecs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

@@ hdl/ecs_front.sv @@
// front section: accepts candidate beats, counts them within a sample and classifies them
// depends on ecs_pkg
`default_nettype none

module ecs_front #(
   parameter int MAX_CANDIDATES = ecs_pkg::MAX_CANDIDATES
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   input  wire logic signed [ecs_pkg::COORD_W-1:0] line_start_x,
   input  wire logic signed [ecs_pkg::COORD_W-1:0] line_start_y,
   input  wire logic signed [ecs_pkg::COORD_W-1:0] normal_x,
   input  wire logic signed [ecs_pkg::COORD_W-1:0] normal_y,
   input  wire logic signed [ecs_pkg::COORD_W-1:0] cand_x,
   input  wire logic signed [ecs_pkg::COORD_W-1:0] cand_y,
   input  wire logic                               cand_valid,
   input  wire logic [ecs_pkg::RESP_W-1:0]         edge_response,
   input  wire logic                               sample_enabled,
   input  wire logic                               last_candidate,
   input  wire logic                               mid_full,
   output logic                                    mid_wr_en,
   output ecs_pkg::mid_item_type                   mid_item
);

   localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);

   logic [CNT_W-1:0] cand_counter_ff, cand_counter_in;
   logic             below_max;

   assign mid_wr_en = push && !mid_full;
   assign below_max = (cand_counter_ff < CNT_W'(MAX_CANDIDATES));

   always_comb begin
      mid_item.dx         = ecs_pkg::DIFF_W'(cand_x) - ecs_pkg::DIFF_W'(line_start_x);
      mid_item.dy         = ecs_pkg::DIFF_W'(cand_y) - ecs_pkg::DIFF_W'(line_start_y);
      mid_item.nx         = normal_x;
      mid_item.ny         = normal_y;
      mid_item.resp       = edge_response;
      mid_item.idx        = ecs_pkg::IDX_W'(cand_counter_ff);
      mid_item.considered = cand_valid && sample_enabled && below_max;
      mid_item.last       = last_candidate;
      mid_item.enabled    = sample_enabled;
   end

   always_comb begin
      cand_counter_in = cand_counter_ff;
      if (mid_wr_en) begin
         if (last_candidate) begin
            cand_counter_in = '0;
         end else if (below_max) begin
            cand_counter_in = cand_counter_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_counter_ff <= '0;
      end else begin
         cand_counter_ff <= cand_counter_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/ecs_back.sv @@
// back section: distance pipeline, winner tracking and result forming
// depends on ecs_pkg
`default_nettype none

module ecs_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ecs_pkg::mid_item_type         mid_item,
   input  wire logic                          mid_empty,
   output logic                               mid_rd_en,
   input  wire logic                          select_mode,
   input  wire logic [ecs_pkg::ABS_W-1:0]     distance_limit,
   input  wire logic                          out_full,
   output logic                               out_wr_en,
   output ecs_pkg::rsp_item_type              out_item
);

   localparam int RND_W = ecs_pkg::ACC_W + 1;
   localparam int D_W   = RND_W - ecs_pkg::ROUND_SHIFT;

   // stage a: products
   logic                              a_valid_ff, a_valid_in;
   ecs_pkg::back_ctl_type             a_ctl_ff;
   logic signed [ecs_pkg::PROD_W-1:0] a_px_ff, a_py_ff;
   // stage b: rounded distance and magnitude
   logic                              b_valid_ff, b_valid_in;
   ecs_pkg::back_ctl_type             b_ctl_ff;
   logic signed [ecs_pkg::DIST_W-1:0] b_dist_ff;
   logic [ecs_pkg::ABS_W-1:0]         b_abs_ff;
   // stage c inputs
   logic                              c_valid_ff, c_valid_in;
   ecs_pkg::back_ctl_type             c_ctl_ff;
   logic signed [ecs_pkg::DIST_W-1:0] c_dist_ff;
   logic [ecs_pkg::ABS_W-1:0]         c_abs_ff;

   // winner of the current sample
   logic                              found_any_ff, found_any_in;
   logic [ecs_pkg::IDX_W-1:0]         held_index_ff, held_index_in;
   logic signed [ecs_pkg::DIST_W-1:0] held_signed_ff, held_signed_in;
   logic [ecs_pkg::ABS_W-1:0]         held_abs_ff, held_abs_in;
   logic [ecs_pkg::RESP_W-1:0]        held_response_ff, held_response_in;

   logic                              back_en, c_fire, take;
   logic signed [ecs_pkg::ACC_W-1:0]  acc;
   logic signed [RND_W-1:0]           rnd;
   logic [D_W-1:0]                    d_rnd, d_neg;
   ecs_pkg::back_ctl_type             mid_ctl;

   assign back_en   = !(c_valid_ff && c_ctl_ff.last && out_full);
   assign mid_rd_en = back_en && !mid_empty;
   assign c_fire    = c_valid_ff && back_en;

   assign a_valid_in = back_en ? !mid_empty : a_valid_ff;
   assign b_valid_in = back_en ? a_valid_ff : b_valid_ff;
   assign c_valid_in = back_en ? b_valid_ff : c_valid_ff;

   always_comb begin
      mid_ctl.resp       = mid_item.resp;
      mid_ctl.idx        = mid_item.idx;
      mid_ctl.considered = mid_item.considered;
      mid_ctl.last       = mid_item.last;
      mid_ctl.enabled    = mid_item.enabled;
   end

   always_comb begin
      acc   = ecs_pkg::ACC_W'(a_px_ff) + ecs_pkg::ACC_W'(a_py_ff);
      rnd   = RND_W'(acc) + RND_W'(1 << (ecs_pkg::ROUND_SHIFT - 1));
      d_rnd = rnd[RND_W-1:ecs_pkg::ROUND_SHIFT];
      d_neg = ~d_rnd + 1'b1;
   end

   always_comb begin
      if (!found_any_ff) begin
         take = 1'b1;
      end else if (select_mode == ecs_pkg::MODE_NEAREST) begin
         take = (c_abs_ff < held_abs_ff);
      end else begin
         take = (c_ctl_ff.resp > held_response_ff);
      end
   end

   always_comb begin
      found_any_in     = found_any_ff;
      held_index_in    = held_index_ff;
      held_signed_in   = held_signed_ff;
      held_abs_in      = held_abs_ff;
      held_response_in = held_response_ff;
      if (c_ctl_ff.considered && take) begin
         found_any_in     = 1'b1;
         held_index_in    = c_ctl_ff.idx;
         held_signed_in   = c_dist_ff;
         held_abs_in      = c_abs_ff;
         held_response_in = c_ctl_ff.resp;
      end
   end

   always_comb begin
      out_wr_en                = c_fire && c_ctl_ff.last && found_any_in && c_ctl_ff.enabled;
      out_item.best_index      = held_index_in;
      out_item.signed_distance = held_signed_in;
      out_item.abs_distance    = held_abs_in;
      out_item.is_inlier       = (held_abs_in < distance_limit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff       <= 1'b0;
         b_valid_ff       <= 1'b0;
         c_valid_ff       <= 1'b0;
         found_any_ff     <= 1'b0;
         held_index_ff    <= '0;
         held_signed_ff   <= '0;
         held_abs_ff      <= ecs_pkg::HELD_ABS_RESET;
         held_response_ff <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         if (c_fire) begin
            if (c_ctl_ff.last) begin
               found_any_ff     <= 1'b0;
               held_index_ff    <= '0;
               held_signed_ff   <= '0;
               held_abs_ff      <= ecs_pkg::HELD_ABS_RESET;
               held_response_ff <= '0;
            end else begin
               found_any_ff     <= found_any_in;
               held_index_ff    <= held_index_in;
               held_signed_ff   <= held_signed_in;
               held_abs_ff      <= held_abs_in;
               held_response_ff <= held_response_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         a_ctl_ff  <= mid_ctl;
         a_px_ff   <= mid_item.dx * mid_item.nx;
         a_py_ff   <= mid_item.dy * mid_item.ny;
         b_ctl_ff  <= a_ctl_ff;
         b_dist_ff <= ecs_pkg::DIST_W'($signed(d_rnd));
         b_abs_ff  <= d_rnd[D_W-1] ? ecs_pkg::ABS_W'(d_neg) : ecs_pkg::ABS_W'(d_rnd);
         c_ctl_ff  <= b_ctl_ff;
         c_dist_ff <= b_dist_ff;
         c_abs_ff  <= b_abs_ff;
      end
   end

endmodule

`default_nettype wire

@@ hdl/edge_candidate_selector.sv @@
// Edge candidate selector. Takes one candidate beat per clock cycle while full is low,
// with no gap between samples. Each beat goes through the front counter into a
// four-entry queue, then a three-stage back pipeline (multiply, round, compare and
// update); the winner of a sample is written into the four-entry result queue from the
// compare stage once the last beat of the sample has passed the multiply and round
// stages, and is registered there before it shows on the rsp ports. The back
// pipeline stalls only while a last beat waits on a full result queue; the front keeps
// accepting beats until its own queue fills.
// depends on ecs_pkg, ecs_fifo, ecs_front, ecs_back
`default_nettype none

module edge_candidate_selector #(
   parameter int MAX_CANDIDATES = ecs_pkg::MAX_CANDIDATES
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // candidate beats
   input  wire logic                                  push,
   output logic                                       full,
   input  wire logic signed [ecs_pkg::COORD_W-1:0]    req_line_start_x,
   input  wire logic signed [ecs_pkg::COORD_W-1:0]    req_line_start_y,
   input  wire logic signed [ecs_pkg::COORD_W-1:0]    req_normal_x,
   input  wire logic signed [ecs_pkg::COORD_W-1:0]    req_normal_y,
   input  wire logic signed [ecs_pkg::COORD_W-1:0]    req_cand_x,
   input  wire logic signed [ecs_pkg::COORD_W-1:0]    req_cand_y,
   input  wire logic                                  req_cand_valid,
   input  wire logic [ecs_pkg::RESP_W-1:0]            req_edge_response,
   input  wire logic                                  req_sample_enabled,
   input  wire logic                                  req_last_candidate,
   // result beats
   output logic                                       empty,
   input  wire logic                                  pop,
   output logic [ecs_pkg::IDX_W-1:0]                  rsp_best_index,
   output logic signed [ecs_pkg::DIST_W-1:0]          rsp_signed_distance,
   output logic [ecs_pkg::ABS_W-1:0]                  rsp_abs_distance,
   output logic                                       rsp_is_inlier,
   // register port
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [ecs_pkg::CSR_ADDR_W-1:0]        paddr,
   input  wire logic [ecs_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [ecs_pkg::CSR_DATA_W-1:0]             prdata,
   output logic                                       pready
);

   localparam int MID_W = $bits(ecs_pkg::mid_item_type);
   localparam int RSP_W = $bits(ecs_pkg::rsp_item_type);

   logic                          select_mode_ff, select_mode_in;
   logic [ecs_pkg::ABS_W-1:0]     distance_limit_ff, distance_limit_in;
   ecs_pkg::csr_index_type        csr_index;
   logic                          csr_wr;

   logic                          mid_full, mid_empty, mid_wr_en, mid_rd_en;
   ecs_pkg::mid_item_type         mid_wr_item, mid_rd_item;
   logic                          out_full, out_wr_en;
   ecs_pkg::rsp_item_type         out_wr_item, out_rd_item;

   assign pready    = 1'b1;
   assign csr_index = ecs_pkg::csr_index_type'(paddr[2]);
   assign csr_wr    = psel && penable && pwrite && pready;

   always_comb begin
      select_mode_in    = select_mode_ff;
      distance_limit_in = distance_limit_ff;
      if (csr_wr) begin
         unique case (csr_index)
            ecs_pkg::REG_SELECT_MODE:    select_mode_in    = pwdata[0];
            ecs_pkg::REG_DISTANCE_LIMIT: distance_limit_in = pwdata[ecs_pkg::ABS_W-1:0];
            default:                     select_mode_in    = select_mode_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         ecs_pkg::REG_SELECT_MODE:    prdata = ecs_pkg::CSR_DATA_W'(select_mode_ff);
         ecs_pkg::REG_DISTANCE_LIMIT: prdata = ecs_pkg::CSR_DATA_W'(distance_limit_ff);
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         select_mode_ff    <= ecs_pkg::MODE_NEAREST;
         distance_limit_ff <= ecs_pkg::DISTANCE_LIMIT_RESET;
      end else begin
         select_mode_ff    <= select_mode_in;
         distance_limit_ff <= distance_limit_in;
      end
   end

   assign full = mid_full;

   ecs_front #(
      .MAX_CANDIDATES(MAX_CANDIDATES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .line_start_x   (req_line_start_x),
      .line_start_y   (req_line_start_y),
      .normal_x       (req_normal_x),
      .normal_y       (req_normal_y),
      .cand_x         (req_cand_x),
      .cand_y         (req_cand_y),
      .cand_valid     (req_cand_valid),
      .edge_response  (req_edge_response),
      .sample_enabled (req_sample_enabled),
      .last_candidate (req_last_candidate),
      .mid_full       (mid_full),
      .mid_wr_en      (mid_wr_en),
      .mid_item       (mid_wr_item)
   );

   ecs_fifo #(
      .WIDTH(MID_W),
      .DEPTH(ecs_pkg::MID_DEPTH)
   ) u_mid_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mid_wr_en),
      .wr_data (mid_wr_item),
      .full    (mid_full),
      .rd_en   (mid_rd_en),
      .rd_data (mid_rd_item),
      .empty   (mid_empty)
   );

   ecs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .mid_item       (mid_rd_item),
      .mid_empty      (mid_empty),
      .mid_rd_en      (mid_rd_en),
      .select_mode    (select_mode_ff),
      .distance_limit (distance_limit_ff),
      .out_full       (out_full),
      .out_wr_en      (out_wr_en),
      .out_item       (out_wr_item)
   );

   ecs_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(ecs_pkg::OUT_DEPTH)
   ) u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (out_wr_en),
      .wr_data (out_wr_item),
      .full    (out_full),
      .rd_en   (pop),
      .rd_data (out_rd_item),
      .empty   (empty)
   );

   assign rsp_best_index      = out_rd_item.best_index;
   assign rsp_signed_distance = out_rd_item.signed_distance;
   assign rsp_abs_distance    = out_rd_item.abs_distance;
   assign rsp_is_inlier       = out_rd_item.is_inlier;

endmodule

`default_nettype wire

@@ hdl/ecs_checker.sv @@
// port-level checks of the edge candidate selector and their binding
// depends on ecs_pkg and edge_candidate_selector
`default_nettype none

module ecs_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 push,
   input wire logic                                 full,
   input wire logic                                 empty,
   input wire logic                                 pop,
   input wire logic [ecs_pkg::IDX_W-1:0]            rsp_best_index,
   input wire logic signed [ecs_pkg::DIST_W-1:0]    rsp_signed_distance,
   input wire logic [ecs_pkg::ABS_W-1:0]            rsp_abs_distance,
   input wire logic                                 rsp_is_inlier
);

   logic [ecs_pkg::DIST_W-1:0] dist_neg;
   logic [ecs_pkg::ABS_W-1:0]  dist_mag;

   assign dist_neg = ~rsp_signed_distance + 1'b1;
   assign dist_mag = rsp_signed_distance[ecs_pkg::DIST_W-1]
                     ? ecs_pkg::ABS_W'(dist_neg)
                     : ecs_pkg::ABS_W'(rsp_signed_distance);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("queues not cleared by reset");

   a_abs_matches: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_abs_distance == dist_mag)
      else $error("abs distance disagrees with signed distance");

   a_full_needs_push: assert property (@(posedge clock) disable iff (reset)
      $rose(full) |-> $past(push))
      else $error("full rose without a beat pushed");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_best_index)
         && $stable(rsp_signed_distance) && $stable(rsp_is_inlier))
      else $error("waiting result changed");

endmodule

bind edge_candidate_selector ecs_checker u_ecs_checker (.*);

`default_nettype wire

@@ sim/tb_edge_candidate_selector.sv @@
// self-checking testbench of edge_candidate_selector: queued candidate beats, a predictor of
// the per-sample winner, and an in-order check of every result beat under random idling
// depends on ecs_pkg and edge_candidate_selector
`timescale 1ns / 1ps

module tb_edge_candidate_selector;

   localparam int STALL_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 30;
   localparam int PHASE_BEATS = 400;
   localparam int CHUNK_BEATS = 100;
   localparam longint DIST_MAX = 64'sd8388607;
   localparam longint DIST_MIN = -64'sd8388608;

   typedef struct {
      logic signed [ecs_pkg::COORD_W-1:0] line_start_x;
      logic signed [ecs_pkg::COORD_W-1:0] line_start_y;
      logic signed [ecs_pkg::COORD_W-1:0] normal_x;
      logic signed [ecs_pkg::COORD_W-1:0] normal_y;
      logic signed [ecs_pkg::COORD_W-1:0] cand_x;
      logic signed [ecs_pkg::COORD_W-1:0] cand_y;
      logic                               cand_valid;
      logic [ecs_pkg::RESP_W-1:0]         edge_response;
      logic                               sample_enabled;
      logic                               last_candidate;
   } cand_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic push = 1'b0;
   logic full;
   logic signed [ecs_pkg::COORD_W-1:0] req_line_start_x = '0;
   logic signed [ecs_pkg::COORD_W-1:0] req_line_start_y = '0;
   logic signed [ecs_pkg::COORD_W-1:0] req_normal_x = '0;
   logic signed [ecs_pkg::COORD_W-1:0] req_normal_y = '0;
   logic signed [ecs_pkg::COORD_W-1:0] req_cand_x = '0;
   logic signed [ecs_pkg::COORD_W-1:0] req_cand_y = '0;
   logic req_cand_valid = 1'b0;
   logic [ecs_pkg::RESP_W-1:0] req_edge_response = '0;
   logic req_sample_enabled = 1'b0;
   logic req_last_candidate = 1'b0;

   logic empty;
   logic pop = 1'b0;
   logic [ecs_pkg::IDX_W-1:0] rsp_best_index;
   logic signed [ecs_pkg::DIST_W-1:0] rsp_signed_distance;
   logic [ecs_pkg::ABS_W-1:0] rsp_abs_distance;
   logic rsp_is_inlier;

   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [ecs_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [ecs_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [ecs_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   cand_beat_type pending_cands[$];
   ecs_pkg::rsp_item_type expected_winners[$];

   // register copy and per-sample winner tracking
   ecs_pkg::select_mode_type cur_mode = ecs_pkg::MODE_NEAREST;
   logic [ecs_pkg::ABS_W-1:0] cur_limit = ecs_pkg::DISTANCE_LIMIT_RESET;
   int sample_pos = 0;
   logic have_winner = 1'b0;
   logic [ecs_pkg::IDX_W-1:0] win_index = '0;
   logic signed [ecs_pkg::DIST_W-1:0] win_signed = '0;
   logic [ecs_pkg::ABS_W-1:0] win_abs = ecs_pkg::HELD_ABS_RESET;
   logic [ecs_pkg::RESP_W-1:0] win_resp = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int stall_cycles = 0;
   bit failed = 1'b0;

   edge_candidate_selector dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_line_start_x(req_line_start_x),
      .req_line_start_y(req_line_start_y),
      .req_normal_x(req_normal_x),
      .req_normal_y(req_normal_y),
      .req_cand_x(req_cand_x),
      .req_cand_y(req_cand_y),
      .req_cand_valid(req_cand_valid),
      .req_edge_response(req_edge_response),
      .req_sample_enabled(req_sample_enabled),
      .req_last_candidate(req_last_candidate),
      .empty(empty),
      .pop(pop),
      .rsp_best_index(rsp_best_index),
      .rsp_signed_distance(rsp_signed_distance),
      .rsp_abs_distance(rsp_abs_distance),
      .rsp_is_inlier(rsp_is_inlier),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #4 clock = ~clock;

   function automatic void track_beat(input cand_beat_type c);
      longint dot;
      longint dist_q4;
      longint mag;
      logic take;
      ecs_pkg::rsp_item_type w;
      if (c.cand_valid && c.sample_enabled && sample_pos < ecs_pkg::MAX_CANDIDATES) begin
         dot = (longint'(c.cand_x) - longint'(c.line_start_x)) * longint'(c.normal_x)
             + (longint'(c.cand_y) - longint'(c.line_start_y)) * longint'(c.normal_y);
         dist_q4 = (dot + 64'sd8192) >>> ecs_pkg::ROUND_SHIFT;
         if (dist_q4 > DIST_MAX) dist_q4 = DIST_MAX;
         if (dist_q4 < DIST_MIN) dist_q4 = DIST_MIN;
         mag = (dist_q4 < 0) ? -dist_q4 : dist_q4;
         if (mag > DIST_MAX) mag = DIST_MAX;
         if (!have_winner)
            take = 1'b1;
         else if (cur_mode == ecs_pkg::MODE_NEAREST)
            take = (mag < longint'(win_abs));
         else
            take = (c.edge_response > win_resp);
         if (take) begin
            have_winner = 1'b1;
            win_index = ecs_pkg::IDX_W'(sample_pos);
            win_signed = dist_q4[ecs_pkg::DIST_W-1:0];
            win_abs = mag[ecs_pkg::ABS_W-1:0];
            win_resp = c.edge_response;
         end
      end
      if (sample_pos < ecs_pkg::MAX_CANDIDATES) sample_pos++;
      if (c.last_candidate) begin
         if (have_winner && c.sample_enabled) begin
            w.best_index = win_index;
            w.signed_distance = win_signed;
            w.abs_distance = win_abs;
            w.is_inlier = (win_abs < cur_limit);
            expected_winners.push_back(w);
         end
         sample_pos = 0;
         have_winner = 1'b0;
         win_index = '0;
         win_signed = '0;
         win_abs = ecs_pkg::HELD_ABS_RESET;
         win_resp = '0;
      end
   endfunction

   // candidate beat driver
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            track_beat(pending_cands.pop_front());
         end
         if (!(push && full)) begin
            if (pending_cands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               push <= 1'b1;
               req_line_start_x <= pending_cands[0].line_start_x;
               req_line_start_y <= pending_cands[0].line_start_y;
               req_normal_x <= pending_cands[0].normal_x;
               req_normal_y <= pending_cands[0].normal_y;
               req_cand_x <= pending_cands[0].cand_x;
               req_cand_y <= pending_cands[0].cand_y;
               req_cand_valid <= pending_cands[0].cand_valid;
               req_edge_response <= pending_cands[0].edge_response;
               req_sample_enabled <= pending_cands[0].sample_enabled;
               req_last_candidate <= pending_cands[0].last_candidate;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // result beat monitor
   always @(posedge clock) begin : winner_monitor
      ecs_pkg::rsp_item_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_winners.size() == 0) begin
               $error("result beat with no winner expected");
               failed = 1'b1;
            end else begin
               want = expected_winners.pop_front();
               if (rsp_best_index !== want.best_index) begin
                  $error("best_index expected %0d got %0d", want.best_index, rsp_best_index);
                  failed = 1'b1;
               end
               if (rsp_signed_distance !== want.signed_distance) begin
                  $error("signed_distance expected %0d got %0d",
                         want.signed_distance, rsp_signed_distance);
                  failed = 1'b1;
               end
               if (rsp_abs_distance !== want.abs_distance) begin
                  $error("abs_distance expected %0d got %0d",
                         want.abs_distance, rsp_abs_distance);
                  failed = 1'b1;
               end
               if (rsp_is_inlier !== want.is_inlier) begin
                  $error("is_inlier expected %0d got %0d", want.is_inlier, rsp_is_inlier);
                  failed = 1'b1;
               end
            end
         end
         pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((push && !full) || (pop && !empty) || (psel && penable)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic csr_write(input ecs_pkg::csr_index_type idx,
                            input logic [ecs_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ecs_pkg::CSR_ADDR_W'(int'(idx) * 4);
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         ecs_pkg::REG_SELECT_MODE: cur_mode = ecs_pkg::select_mode_type'(val[0]);
         ecs_pkg::REG_DISTANCE_LIMIT: cur_limit = val[ecs_pkg::ABS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic add_beat(input int sx, input int sy, input int nx, input int ny,
                           input int cx, input int cy,
                           input logic valid, input int resp,
                           input logic en, input logic last);
      cand_beat_type c;
      c.line_start_x = 16'(sx);
      c.line_start_y = 16'(sy);
      c.normal_x = 16'(nx);
      c.normal_y = 16'(ny);
      c.cand_x = 16'(cx);
      c.cand_y = 16'(cy);
      c.cand_valid = valid;
      c.edge_response = 16'(resp);
      c.sample_enabled = en;
      c.last_candidate = last;
      pending_cands.push_back(c);
   endtask

   // one sample with random content, or now and then a lone noise beat
   task automatic add_sample(output int pushed);
      int len;
      int k;
      int kind;
      cand_beat_type c;
      logic signed [ecs_pkg::COORD_W-1:0] sx, sy, nx, ny;
      logic en;
      kind = $urandom_range(99);
      if (kind < 8) begin
         c.line_start_x = 16'($urandom);
         c.line_start_y = 16'($urandom);
         c.normal_x = 16'($urandom);
         c.normal_y = 16'($urandom);
         c.cand_x = 16'($urandom);
         c.cand_y = 16'($urandom);
         c.cand_valid = 1'($urandom);
         c.edge_response = 16'($urandom);
         c.sample_enabled = 1'($urandom);
         c.last_candidate = 1'($urandom);
         pending_cands.push_back(c);
         pushed = 1;
      end else begin
         len = (kind < 18) ? $urandom_range(9, 12) : $urandom_range(1, 8);
         sx = 16'($urandom);
         sy = 16'($urandom);
         if ($urandom_range(99) < 80) begin
            nx = 16'($urandom_range(32768) - 16384);
            ny = 16'($urandom_range(32768) - 16384);
         end else begin
            nx = 16'($urandom);
            ny = 16'($urandom);
         end
         en = ($urandom_range(99) < 90);
         for (k = 0; k < len; k++) begin
            // otherwise repeat the previous candidate to force a tie
            if (k == 0 || $urandom_range(99) >= 15) begin
               if ($urandom_range(99) < 80) begin
                  c.cand_x = sx + 16'($urandom_range(127) - 64);
                  c.cand_y = sy + 16'($urandom_range(127) - 64);
               end else begin
                  c.cand_x = 16'($urandom);
                  c.cand_y = 16'($urandom);
               end
               c.edge_response = $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom);
            end
            c.line_start_x = sx;
            c.line_start_y = sy;
            c.normal_x = nx;
            c.normal_y = ny;
            c.cand_valid = ($urandom_range(99) < 85);
            c.sample_enabled = ($urandom_range(99) < 5) ? !en : en;
            c.last_candidate = (k == len - 1);
            pending_cands.push_back(c);
         end
         pushed = len;
      end
   endtask

   task automatic drain();
      while (pending_cands.size() != 0 || expected_winners.size() != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int p;
      int k;
      int total;
      int chunk;
      int n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (p = 0; p < 4; p++) begin
         @(negedge clock);
         case (p)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
               csr_write(ecs_pkg::REG_SELECT_MODE,
                         ecs_pkg::CSR_DATA_W'(ecs_pkg::MODE_NEAREST));
               csr_write(ecs_pkg::REG_DISTANCE_LIMIT,
                         ecs_pkg::CSR_DATA_W'(ecs_pkg::DISTANCE_LIMIT_RESET));
            end
            1: begin
               send_idle_pct = 79;
               recv_stall_pct = 0;
               csr_write(ecs_pkg::REG_SELECT_MODE,
                         ecs_pkg::CSR_DATA_W'(ecs_pkg::MODE_STRONGEST));
               csr_write(ecs_pkg::REG_DISTANCE_LIMIT, '0);
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 79;
               csr_write(ecs_pkg::REG_SELECT_MODE,
                         ecs_pkg::CSR_DATA_W'(ecs_pkg::MODE_NEAREST));
               csr_write(ecs_pkg::REG_DISTANCE_LIMIT,
                         ecs_pkg::CSR_DATA_W'($urandom_range(1, 300)));
            end
            default: begin
               send_idle_pct = 33;
               recv_stall_pct = 33;
               csr_write(ecs_pkg::REG_SELECT_MODE,
                         ecs_pkg::CSR_DATA_W'(ecs_pkg::MODE_STRONGEST));
               csr_write(ecs_pkg::REG_DISTANCE_LIMIT,
                         ecs_pkg::CSR_DATA_W'($urandom_range(300)));
            end
         endcase
         @(negedge clock);
         if (p == 0) begin
            // field extremes, opposite corners
            add_beat(-32768, 32767, -32768, 32767, 32767, -32768, 1'b1, 16'hffff, 1'b1, 1'b1);
            add_beat(32767, -32768, 32767, -32768, -32768, 32767, 1'b1, 16'h0000, 1'b1, 1'b1);
            // no considered candidate
            add_beat(0, 0, 16384, 0, 100, 0, 1'b0, 16'd500, 1'b1, 1'b1);
            // last beat of a disabled sample
            add_beat(0, 0, 16384, 0, 16, 0, 1'b1, 16'd10, 1'b1, 1'b0);
            add_beat(0, 0, 16384, 0, 32, 0, 1'b1, 16'd10, 1'b0, 1'b1);
            // candidates past the counter limit are ignored
            for (k = 0; k < 10; k++)
               add_beat(0, 0, 0, 16384, 0, (k < 8) ? 16'(16 * (8 - k)) : 16'sd0,
                        1'b1, 16'(k), 1'b1, k == 9);
            // equal candidates, first one wins
            add_beat(0, 0, 16384, 16384, 16, 16, 1'b1, 16'd5, 1'b1, 1'b0);
            add_beat(0, 0, 16384, 16384, 16, 16, 1'b1, 16'd5, 1'b1, 1'b1);
            // rounding of a negative distance
            add_beat(0, 0, 8192, 0, -3, 0, 1'b1, 16'd1, 1'b1, 1'b1);
         end
         total = 0;
         chunk = 0;
         while (total < PHASE_BEATS) begin
            add_sample(n);
            total += n;
            chunk += n;
            if (chunk >= CHUNK_BEATS) begin
               drain();
               chunk = 0;
            end
         end
         // close any open sample before the registers change
         add_beat(0, 0, 0, 0, 0, 0, 1'b0, 16'd0, 1'b1, 1'b1);
         drain();
         repeat (SETTLE_CYCLES) @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_winners.size() != 0) begin
         $error("%0d expected results never arrived", expected_winners.size());
      end
      if (!failed && expected_winners.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
